@@ hdl/ogrrf_pkg.sv @@
// Package for the occupancy grid rigid remap fusion block.
// Holds field widths, function and register codes, reset values and shared types.
// No dependencies.
package ogrrf_pkg;

   // grid size defaults
   localparam int ROWS_DEFAULT = 512;
   localparam int COLS_DEFAULT = 256;

   // width used when comparing coordinates against the grid size
   localparam int DIM_W = 13;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ROT_COS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_VALUE = 3'd6;

   // item function codes
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_FUSE = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // signed landing coordinate, wide enough for any grid size in range
   typedef logic signed [17:0] coord_type;

   typedef struct packed {
      logic signed [15:0] rot_cos;
      logic signed [15:0] rot_sin;
      logic signed [23:0] trans_x;
      logic signed [23:0] trans_y;
      logic [8:0]         center_row;
      logic [7:0]         center_col;
      logic [7:0]         mark_value;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rot_cos:    16'sd16384,
      rot_sin:    16'sd0,
      trans_x:    24'sd0,
      trans_y:    24'sd0,
      center_row: 9'd256,
      center_col: 8'd128,
      mark_value: 8'd1
   };

   typedef struct packed {
      logic [1:0] func;
      logic [8:0] cell_row;
      logic [7:0] cell_col;
      logic [7:0] cell_value;
   } item_type;

   // stage advance strobes for the remap datapath
   typedef struct packed {
      logic mul;
      logic sum;
      logic tgt;
   } stage_type;

   // landing cell of a fuse
   typedef struct packed {
      logic      hit;
      coord_type row;
      coord_type col;
   } tgt_type;

endpackage

@@ hdl/ogrrf_intf.sv @@
// Handshake channel interfaces for the remap fusion block: request and response.
// Each carries valid, ready and the item payload. No dependencies.
interface ogrrf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [8:0] cell_row;
   logic [7:0] cell_col;
   logic [7:0] cell_value;

   modport source (output valid, func, cell_row, cell_col, cell_value, input ready);
   modport sink   (input valid, func, cell_row, cell_col, cell_value, output ready);
endinterface

interface ogrrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_value;
   logic       cell_written;
   logic [8:0] target_row;
   logic [7:0] target_col;

   modport source (output valid, read_value, cell_written, target_row, target_col,
                   input ready);
   modport sink   (input valid, read_value, cell_written, target_row, target_col,
                   output ready);
endinterface

@@ hdl/occupancy_grid_rigid_remap_fusion.sv @@
// Occupancy grid fusion by rigid remap. The fused grid (ROWS x COLS bytes) sits in
// one synchronous RAM and is undefined after reset until cells are loaded or fused;
// there is no clearing pass. Items are handled one at a time by a sequencer: a load or
// an empty or unused-code item goes straight to the finish state, a read passes a RAM
// read state, an occupied-cell fuse three remap arithmetic stages, then the grid write.
// A finished response waits in an output register, so the next item is accepted
// while it is pending. Write configuration registers only while the block is idle.
// Depends on ogrrf_pkg, ogrrf_intf, ogrrf_ram and ogrrf_remap.
module occupancy_grid_rigid_remap_fusion
   import ogrrf_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   ogrrf_req_if.sink             req,
   ogrrf_rsp_if.source           rsp
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 2 ** AW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_TGT  = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]    state_in, state_ff;
   cfg_type       cfg_in, cfg_ff;
   item_type      item_in, item_ff;
   logic          rsp_valid_in, rsp_valid_ff;
   logic [7:0]    read_value_in, read_value_ff;
   logic          cell_written_in, cell_written_ff;
   logic [8:0]    target_row_in, target_row_ff;
   logic [7:0]    target_col_in, target_col_ff;
   stage_type     stage;
   tgt_type       tgt;
   logic          addr_in_grid;
   logic          fuse_hit;
   logic          finish;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] item_addr;
   logic [7:0]    rd_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_COS:    cfg_in.rot_cos    = csr_wdata[15:0];
            CSR_ROT_SIN:    cfg_in.rot_sin    = csr_wdata[15:0];
            CSR_TRANS_X:    cfg_in.trans_x    = csr_wdata[23:0];
            CSR_TRANS_Y:    cfg_in.trans_y    = csr_wdata[23:0];
            CSR_CENTER_ROW: cfg_in.center_row = csr_wdata[8:0];
            CSR_CENTER_COL: cfg_in.center_col = csr_wdata[7:0];
            CSR_MARK_VALUE: cfg_in.mark_value = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // address of the item's own cell, for loads and reads
   assign addr_in_grid = (DIM_W'(item_ff.cell_row) < DIM_W'(ROWS)) &&
                         (DIM_W'(item_ff.cell_col) < DIM_W'(COLS));
   assign item_addr    = {RW'(item_ff.cell_row), CW'(item_ff.cell_col)};
   assign fuse_hit     = (item_ff.func == FUNC_FUSE) && (item_ff.cell_value != 8'd0) &&
                         tgt.hit;

   // output slot free this cycle
   assign finish = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp.ready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      stage     = '0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               item_in = '{func: req.func, cell_row: req.cell_row,
                           cell_col: req.cell_col, cell_value: req.cell_value};
               priority if (req.func == FUNC_FUSE && req.cell_value != 8'd0) begin
                  state_in = ST_MUL;
               end else if (req.func == FUNC_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MUL: begin
            stage.mul = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            stage.sum = 1'b1;
            state_in  = ST_TGT;
         end
         ST_TGT: begin
            stage.tgt = 1'b1;
            state_in  = ST_FIN;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // grid write at the end of a load or a landing fuse
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = item_addr;
      wr_data = item_ff.cell_value;
      if (finish) begin
         if (item_ff.func == FUNC_LOAD && addr_in_grid) begin
            wr_en = 1'b1;
         end else if (fuse_hit) begin
            wr_en   = 1'b1;
            wr_addr = {tgt.row[RW-1:0], tgt.col[CW-1:0]};
            wr_data = cfg_ff.mark_value;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      read_value_in   = read_value_ff;
      cell_written_in = cell_written_ff;
      target_row_in   = target_row_ff;
      target_col_in   = target_col_ff;
      if (finish) begin
         rsp_valid_in    = 1'b1;
         read_value_in   = (item_ff.func == FUNC_READ && addr_in_grid) ? rd_data : 8'd0;
         cell_written_in = fuse_hit;
         target_row_in   = fuse_hit ? tgt.row[8:0] : 9'd0;
         target_col_in   = fuse_hit ? tgt.col[7:0] : 8'd0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      read_value_ff   <= read_value_in;
      cell_written_ff <= cell_written_in;
      target_row_ff   <= target_row_in;
      target_col_ff   <= target_col_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.read_value   = read_value_ff;
   assign rsp.cell_written = cell_written_ff;
   assign rsp.target_row   = target_row_ff;
   assign rsp.target_col   = target_col_ff;

   ogrrf_remap #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_remap (
      .clock   (clock),
      .cfg     (cfg_ff),
      .src_row (item_ff.cell_row),
      .src_col (item_ff.cell_col),
      .stage   (stage),
      .tgt     (tgt)
   );

   ogrrf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (item_addr),
      .rd_data (rd_data)
   );

endmodule

@@ hdl/ogrrf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ogrrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ogrrf_remap.sv @@
// Remap datapath: rotates a source cell offset, adds the translation and finds
// the landing cell, in three registered stages. Depends on ogrrf_pkg.
module ogrrf_remap
   import ogrrf_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic      clock,
   input  cfg_type   cfg,
   input  logic [8:0] src_row,
   input  logic [7:0] src_col,
   input  stage_type stage,
   output tgt_type   tgt
);

   logic signed [8:0]  dx;
   logic signed [9:0]  dy;
   logic signed [24:0] cx_in, sx_in, cx_ff, sx_ff;
   logic signed [25:0] sy_in, cy_in, sy_ff, cy_ff;
   logic signed [26:0] rx, ry, rx_adj, ry_adj;
   logic signed [20:0] rx_q8, ry_q8;
   logic signed [24:0] qx_in, qy_in, qx_ff, qy_ff;
   logic signed [24:0] qx_adj, qy_adj;
   logic signed [16:0] ix, iy;
   tgt_type            tgt_in, tgt_ff;

   // stage 1: offsets from the vehicle center and the four products
   always_comb begin
      dx    = $signed({1'b0, src_col}) - $signed({1'b0, cfg.center_col});
      dy    = $signed({1'b0, cfg.center_row}) - $signed({1'b0, src_row});
      cx_in = $signed(cfg.rot_cos) * dx;
      sx_in = $signed(cfg.rot_sin) * dx;
      sy_in = $signed(cfg.rot_sin) * dy;
      cy_in = $signed(cfg.rot_cos) * dy;
   end

   // stage 2: rotate, cut Q14 to Q8 toward zero, add translation
   always_comb begin
      rx     = 27'(cx_ff) - 27'(sy_ff);
      ry     = 27'(sx_ff) + 27'(cy_ff);
      rx_adj = rx + (rx[26] ? 27'sd63 : 27'sd0);
      ry_adj = ry + (ry[26] ? 27'sd63 : 27'sd0);
      rx_q8  = 21'(rx_adj >>> 6);
      ry_q8  = 21'(ry_adj >>> 6);
      qx_in  = 25'(rx_q8) + 25'($signed(cfg.trans_x));
      qy_in  = 25'(ry_q8) + 25'($signed(cfg.trans_y));
   end

   // stage 3: whole cells toward zero, landing cell and grid bounds
   always_comb begin
      qx_adj     = qx_ff + (qx_ff[24] ? 25'sd255 : 25'sd0);
      qy_adj     = qy_ff + (qy_ff[24] ? 25'sd255 : 25'sd0);
      ix         = 17'(qx_adj >>> 8);
      iy         = 17'(qy_adj >>> 8);
      tgt_in.col = 18'($signed({1'b0, cfg.center_col})) + 18'(ix);
      tgt_in.row = 18'($signed({1'b0, cfg.center_row})) - 18'(iy);
      tgt_in.hit = !tgt_in.row[17] && (tgt_in.row < 18'(ROWS)) &&
                   !tgt_in.col[17] && (tgt_in.col < 18'(COLS));
   end

   always_ff @(posedge clock) begin
      if (stage.mul) begin
         cx_ff <= cx_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         cy_ff <= cy_in;
      end
      if (stage.sum) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
      if (stage.tgt) begin
         tgt_ff <= tgt_in;
      end
   end

   assign tgt = tgt_ff;

endmodule

@@ tb/ogrrf_fusion_checker.sv @@
// Checker for the occupancy grid remap fusion block: mirrors configuration writes and
// the fused grid, predicts one reply per accepted item and compares it with the block.
// Depends on ogrrf_pkg and the ogrrf_req_if / ogrrf_rsp_if interfaces.
module ogrrf_fusion_checker
   import ogrrf_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   ogrrf_req_if                  req,
   ogrrf_rsp_if                  rsp,
   output int                    mismatch_count,
   output int                    replies_due
);

   typedef struct packed {
      logic [7:0] read_value;
      logic       cell_written;
      logic [8:0] target_row;
      logic [7:0] target_col;
   } reply_type;

   cfg_type    frame_cfg = CFG_RESET;
   logic [7:0] grid_mirror [ROWS*COLS];
   reply_type  replies_owed [$];
   int         errors = 0;

   // apply one accepted item to the mirrored grid, return the reply it causes
   function automatic reply_type remap_outcome(input item_type op);
      reply_type reply;
      longint    dx, dy, rx, ry, qx, qy, land_row, land_col;
      bit        own_in_grid;
      reply = '0;
      // loads and reads outside the grid are ignored and read back as zero
      own_in_grid = (int'(op.cell_row) < ROWS) && (int'(op.cell_col) < COLS);
      case (op.func)
         FUNC_LOAD: begin
            if (own_in_grid) begin
               grid_mirror[int'(op.cell_row) * COLS + int'(op.cell_col)] = op.cell_value;
            end
         end
         FUNC_READ: begin
            if (own_in_grid) begin
               reply.read_value = grid_mirror[int'(op.cell_row) * COLS + int'(op.cell_col)];
            end
         end
         FUNC_FUSE: begin
            // empty source cells leave the grid alone
            if (op.cell_value != 8'd0) begin
               dx = longint'(op.cell_col) - longint'(frame_cfg.center_col);
               dy = longint'(frame_cfg.center_row) - longint'(op.cell_row);
               rx = longint'($signed(frame_cfg.rot_cos)) * dx
                    - longint'($signed(frame_cfg.rot_sin)) * dy;
               ry = longint'($signed(frame_cfg.rot_sin)) * dx
                    + longint'($signed(frame_cfg.rot_cos)) * dy;
               // Q14 -> Q8, add shift, Q8 -> whole cells; each cut truncates toward zero
               qx = rx / 64 + longint'($signed(frame_cfg.trans_x));
               qy = ry / 64 + longint'($signed(frame_cfg.trans_y));
               land_col = longint'(frame_cfg.center_col) + qx / 256;
               land_row = longint'(frame_cfg.center_row) - qy / 256;
               if (land_row >= 0 && land_row < ROWS && land_col >= 0 && land_col < COLS) begin
                  grid_mirror[land_row * COLS + land_col] = frame_cfg.mark_value;
                  reply.cell_written = 1'b1;
                  reply.target_row   = 9'(land_row);
                  reply.target_col   = 8'(land_col);
               end
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] expected,
                                       input logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
         errors++;
      end
   endfunction

   // configuration mirror, prediction on input accept, compare on reply accept
   always @(posedge clock) begin
      item_type  op;
      reply_type owed;
      if (reset) begin
         frame_cfg = CFG_RESET;
         replies_owed.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROT_COS:    frame_cfg.rot_cos    = csr_wdata[15:0];
               CSR_ROT_SIN:    frame_cfg.rot_sin    = csr_wdata[15:0];
               CSR_TRANS_X:    frame_cfg.trans_x    = csr_wdata;
               CSR_TRANS_Y:    frame_cfg.trans_y    = csr_wdata;
               CSR_CENTER_ROW: frame_cfg.center_row = csr_wdata[8:0];
               CSR_CENTER_COL: frame_cfg.center_col = csr_wdata[7:0];
               CSR_MARK_VALUE: frame_cfg.mark_value = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            op   = {req.func, req.cell_row, req.cell_col, req.cell_value};
            owed = remap_outcome(op);
            replies_owed.insert(replies_owed.size(), owed);
         end
         if (rsp.valid && rsp.ready) begin
            if (replies_owed.size() == 0) begin
               $display("%0t: reply with none expected, expected none, actual %0d/%0d/%0d/%0d",
                        $time, rsp.read_value, rsp.cell_written, rsp.target_row,
                        rsp.target_col);
               errors++;
            end else begin
               owed = replies_owed.pop_front();
               check_field("read_value", owed.read_value, rsp.read_value);
               check_field("cell_written", owed.cell_written, rsp.cell_written);
               check_field("target_row", owed.target_row, rsp.target_row);
               check_field("target_col", owed.target_col, rsp.target_col);
            end
         end
      end
      mismatch_count <= errors;
      replies_due    <= replies_owed.size();
   end

endmodule

@@ tb/occupancy_grid_rigid_remap_fusion_test.sv @@
// Top of the remap fusion testbench: clock, reset, configuration frames, item stimulus
// and reply back-pressure around the block, with ogrrf_fusion_checker alongside.
// Depends on ogrrf_pkg, the channel interfaces, the block and the checker.
module occupancy_grid_rigid_remap_fusion_test
   import ogrrf_pkg::*;
();

   localparam int ROWS          = ROWS_DEFAULT;
   localparam int COLS          = COLS_DEFAULT;
   localparam int PHASES        = 10;
   localparam int OPS_PER_PHASE = 190;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRESSURE_OPS  = 80;

   // code outside the defined function set
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef enum logic [1:0] {DRAIN_ALWAYS, DRAIN_COIN, DRAIN_SPARSE, DRAIN_CADENCE}
      drain_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    replies_due;

   ogrrf_req_if req_ch ();
   ogrrf_rsp_if rsp_ch ();

   cfg_type frame;
   bit      cell_loaded [ROWS*COLS];
   int      loaded_cells [$];
   int      burst_left   = 0;
   bit      steady_flow  = 1'b0;
   bit      hold_request = 1'b0;

   occupancy_grid_rigid_remap_fusion #(.ROWS(ROWS), .COLS(COLS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   ogrrf_fusion_checker #(.ROWS(ROWS), .COLS(COLS)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .mismatch_count (mismatch_count),
      .replies_due    (replies_due)
   );

   always #5 clock = ~clock;

   // run limit
   initial begin
      #6000000;
      $display("occupancy_grid_rigid_remap_fusion_test failed");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // upper bits beyond a register's width carry junk on purpose
   task automatic apply_frame();
      write_reg(CSR_ROT_COS, {8'($urandom), frame.rot_cos});
      write_reg(CSR_ROT_SIN, {8'($urandom), frame.rot_sin});
      write_reg(CSR_TRANS_X, frame.trans_x);
      write_reg(CSR_TRANS_Y, frame.trans_y);
      write_reg(CSR_CENTER_ROW, {15'($urandom), frame.center_row});
      write_reg(CSR_CENTER_COL, {16'($urandom), frame.center_col});
      write_reg(CSR_MARK_VALUE, {16'($urandom), frame.mark_value});
      csr_we <= 1'b0;
   endtask

   // stop offering and wait until every reply is back, then let the block settle
   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (replies_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // offer one item, wait for accept, then maybe open a gap between bursts
   task automatic send_cell_op(input item_type op);
      int gap;
      int addr;
      req_ch.valid      <= 1'b1;
      req_ch.func       <= op.func;
      req_ch.cell_row   <= op.cell_row;
      req_ch.cell_col   <= op.cell_col;
      req_ch.cell_value <= op.cell_value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      addr = int'(op.cell_row) * COLS + int'(op.cell_col);
      if (op.func == FUNC_LOAD && !cell_loaded[addr]) begin
         cell_loaded[addr] = 1'b1;
         loaded_cells.insert(loaded_cells.size(), addr);
      end
      if (!steady_flow) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(0, 24);
         end
      end
   endtask

   // random item; half of them sit near the vehicle center so fuses mostly land inside
   task automatic pick_cell_op(output item_type op);
      int roll;
      int addr;
      roll          = $urandom_range(0, 99);
      op.func       = FUNC_LOAD;
      op.cell_row   = 9'($urandom);
      op.cell_col   = 8'($urandom);
      op.cell_value = 8'($urandom);
      if ($urandom_range(0, 1) == 1) begin
         op.cell_row = 9'(int'(frame.center_row) + int'($urandom_range(0, 80)) - 40);
         op.cell_col = 8'(int'(frame.center_col) + int'($urandom_range(0, 80)) - 40);
      end
      if (roll < 30) begin
         op.func = FUNC_LOAD;
      end else if (roll < 68) begin
         op.func = FUNC_FUSE;
      end else if (roll < 74) begin
         op.func       = FUNC_FUSE;
         op.cell_value = 8'd0;
      end else if (roll < 95 && loaded_cells.size() != 0) begin
         // only cells already written are read back
         op.func     = FUNC_READ;
         addr        = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
         op.cell_row = 9'(addr / COLS);
         op.cell_col = 8'(addr % COLS);
      end else begin
         op.func = FUNC_UNUSED;
      end
   endtask

   // first phases pin the extremes, the rest are random headings and shifts
   task automatic choose_frame(input int phase);
      real angle;
      case (phase)
         0: frame = '{rot_cos: 16'shC000, rot_sin: 16'sh4000, trans_x: 24'sh000000,
                      trans_y: 24'sh000000, center_row: 9'd0, center_col: 8'd0,
                      mark_value: 8'h00};
         1: frame = '{rot_cos: 16'sh4000, rot_sin: 16'shC000, trans_x: 24'shFFFED4,
                      trans_y: 24'sh0002BC, center_row: 9'd511, center_col: 8'd255,
                      mark_value: 8'hFF};
         2: frame = '{rot_cos: 16'sh4000, rot_sin: 16'sh0000, trans_x: 24'sh7FFFFF,
                      trans_y: 24'sh800000, center_row: 9'd256, center_col: 8'd128,
                      mark_value: 8'h55};
         default: begin
            angle         = $urandom_range(0, 62831) / 10000.0;
            frame.rot_cos = 16'(int'($cos(angle) * 16384.0));
            frame.rot_sin = 16'(int'($sin(angle) * 16384.0));
            if ($urandom_range(0, 3) == 0) begin
               frame.rot_cos = 16'(int'($urandom_range(0, 32768)) - 16384);
               frame.rot_sin = 16'(int'($urandom_range(0, 32768)) - 16384);
            end
            frame.trans_x = 24'(int'($urandom_range(0, 16384)) - 8192);
            frame.trans_y = 24'(int'($urandom_range(0, 16384)) - 8192);
            if ($urandom_range(0, 5) == 0) frame.trans_x = 24'($urandom);
            if ($urandom_range(0, 5) == 0) frame.trans_y = 24'($urandom);
            frame.center_row = 9'($urandom);
            frame.center_col = 8'($urandom);
            frame.mark_value = 8'($urandom);
         end
      endcase
   endtask

   // reply side back-pressure, plus one long hold when asked
   initial begin : drain_side
      drain_mode_type mode;
      int             mode_left;
      int             cadence;
      bit             hold_served;
      mode        = DRAIN_ALWAYS;
      mode_left   = 0;
      cadence     = 0;
      hold_served = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_served) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = drain_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         cadence++;
         case (mode)
            DRAIN_ALWAYS: rsp_ch.ready <= 1'b1;
            DRAIN_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            default:      rsp_ch.ready <= (cadence % 7) < 4;
         endcase
         @(posedge clock);
      end
   end

   initial begin : stimulus
      item_type op;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_ROT_COS;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_LOAD;
      req_ch.cell_row   <= '0;
      req_ch.cell_col   <= '0;
      req_ch.cell_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      frame = CFG_RESET;

      // reset frame: grid corners, identity fuse, empty source, unused code
      send_cell_op(item_type'{FUNC_LOAD, 9'd0, 8'd0, 8'hFF});
      send_cell_op(item_type'{FUNC_LOAD, 9'd511, 8'd255, 8'h00});
      send_cell_op(item_type'{FUNC_LOAD, 9'd256, 8'd128, 8'hA5});
      send_cell_op(item_type'{FUNC_LOAD, 9'd257, 8'd128, 8'h3C});
      send_cell_op(item_type'{FUNC_READ, 9'd0, 8'd0, 8'h00});
      send_cell_op(item_type'{FUNC_READ, 9'd511, 8'd255, 8'hFF});
      send_cell_op(item_type'{FUNC_READ, 9'd256, 8'd128, 8'h00});
      send_cell_op(item_type'{FUNC_FUSE, 9'd256, 8'd128, 8'h80});
      send_cell_op(item_type'{FUNC_READ, 9'd256, 8'd128, 8'h00});
      send_cell_op(item_type'{FUNC_FUSE, 9'd0, 8'd0, 8'h00});
      send_cell_op(item_type'{FUNC_FUSE, 9'd0, 8'd0, 8'h01});
      send_cell_op(item_type'{FUNC_READ, 9'd0, 8'd0, 8'h00});
      send_cell_op(item_type'{FUNC_FUSE, 9'd511, 8'd255, 8'hFF});
      send_cell_op(item_type'{FUNC_READ, 9'd511, 8'd255, 8'h00});
      send_cell_op(item_type'{FUNC_UNUSED, 9'd511, 8'd255, 8'hFF});
      drain_replies();

      // shift to the far corner of the range: landing is dropped, grid untouched
      frame.trans_x    = 24'sh7FFFFF;
      frame.trans_y    = 24'sh800000;
      frame.mark_value = 8'hC3;
      apply_frame();
      send_cell_op(item_type'{FUNC_FUSE, 9'd256, 8'd128, 8'h01});
      send_cell_op(item_type'{FUNC_READ, 9'd256, 8'd128, 8'h00});
      drain_replies();

      // negative fractions: -255/256 truncates to 0, -256/256 moves one row down
      frame.trans_x    = 24'shFFFF01;
      frame.trans_y    = 24'shFFFF00;
      frame.mark_value = 8'hFF;
      apply_frame();
      send_cell_op(item_type'{FUNC_FUSE, 9'd256, 8'd128, 8'h02});
      send_cell_op(item_type'{FUNC_READ, 9'd257, 8'd128, 8'h00});

      // random frames; phase 4 backs the block up against a held reply side
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_replies();
         choose_frame(phase);
         apply_frame();
         if (phase == 4) hold_request <= 1'b1;
         steady_flow = (phase == 4) || (phase == 6);
         for (int n = 0; n < OPS_PER_PHASE; n++) begin
            if (phase == 4 && n == PRESSURE_OPS) steady_flow = 1'b0;
            pick_cell_op(op);
            send_cell_op(op);
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < 20000 && replies_due != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && replies_due == 0)
         $display("occupancy_grid_rigid_remap_fusion_test passed");
      else
         $display("occupancy_grid_rigid_remap_fusion_test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/ogrrf_pkg.sv
hdl/ogrrf_intf.sv
hdl/ogrrf_ram.sv
hdl/ogrrf_remap.sv
hdl/occupancy_grid_rigid_remap_fusion.sv
tb/ogrrf_fusion_checker.sv
tb/occupancy_grid_rigid_remap_fusion_test.sv
